/* sv/cidh_pkg.sv */
// ----------------------------------------------------------------------------
// cidh_pkg
// Types and constants shared by the interrupt dispatch and halt block and its
// checker.
// ----------------------------------------------------------------------------
package cidh_pkg;

	// action codes
	localparam logic [3:0] ACT_BOUNDARY   = 4'd0;
	localparam logic [3:0] ACT_WR_FLAGS   = 4'd1;
	localparam logic [3:0] ACT_WR_ENABLES = 4'd2;
	localparam logic [3:0] ACT_READ       = 4'd3;
	localparam logic [3:0] ACT_REQ_VBLANK = 4'd4;
	localparam logic [3:0] ACT_REQ_JOYPAD = 4'd5;
	localparam logic [3:0] ACT_REQ_TIMER  = 4'd6;
	localparam logic [3:0] ACT_HALT       = 4'd7;
	localparam logic [3:0] ACT_SET_MASTER = 4'd8;

	// request sources
	localparam int          SRC_COUNT  = 5;
	localparam logic [7:0]  BIT_VBLANK = 8'h01;
	localparam logic [7:0]  BIT_TIMER  = 8'h04;
	localparam logic [7:0]  BIT_JOYPAD = 8'h10;

	localparam logic [6:0]  VEC_BASE      = 7'h40;
	localparam logic [15:0] PUSH_BYTES    = 16'd2;
	localparam logic [4:0]  DISPATCH_COST = 5'(4 * 5);
	localparam logic [4:0]  IDLE_COST     = 5'd4;

	typedef struct packed {
		logic [3:0]  action;
		logic [7:0]  data;
		logic [15:0] pc_value;
		logic [15:0] sp_value;
	} item_t;

	typedef struct packed {
		logic        dispatch;
		logic [6:0]  vector;
		logic [15:0] push_address;
		logic [15:0] push_value;
		logic [15:0] new_sp;
		logic        fetch;
		logic        hold_pc;
		logic [4:0]  wait_cycles;
		logic [7:0]  flags_read;
		logic [7:0]  enables_read;
		logic        is_halted;
	} result_t;

endpackage

/* sv/cpu_interrupt_dispatch_and_halt.sv */
// ----------------------------------------------------------------------------
// cpu_interrupt_dispatch_and_halt
// Interrupt flag/enable registers, priority dispatch and HALT handling for an
// 8-bit CPU core. One result transaction per input transaction.
// ----------------------------------------------------------------------------
// Pipeline: an input register (stage 1) loads on the accepting edge; the result
//   register (stage 2) loads from it once stage 2 holds no stalled result.
// Throughput: one transaction per cycle while result_stall is low; the block state
//   is read and updated between the input register and the result register.
// Reset: arst_n clears flags, enables, master enable, halted and halt-bug
//   bits, empties both stages, and sets dmg_mode to 1.
// ----------------------------------------------------------------------------
module cpu_interrupt_dispatch_and_halt (
	input  logic             clk,
	input  logic             arst_n,
	// input transactions
	input  logic             item_valid,
	output logic             item_stall,
	input  cidh_pkg::item_t  item,
	// result transactions
	output logic             result_valid,
	input  logic             result_stall,
	output cidh_pkg::result_t result,
	// configuration write (dmg_mode)
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_data
);
	import cidh_pkg::*;

	// ---------------------------------------------------------------------
	// Block state
	// ---------------------------------------------------------------------
	logic       dmg_mode_q;
	logic [7:0] flags_q;
	logic [7:0] enables_q;
	logic       master_q;
	logic       halted_q;
	logic       halt_bug_q;

	// next-state values from the transaction in stage 1
	logic [7:0] flags_d;
	logic [7:0] enables_d;
	logic       master_d;
	logic       halted_d;
	logic       halt_bug_d;

	// ---------------------------------------------------------------------
	// Pipeline control
	// Stage 1 holds the accepted transaction; stage 2 is the result register.
	// Stage 1 frees up whenever stage 2 can load, so a new transaction is
	// taken into an empty stage 1 even while a finished result sits stalled in stage 2.
	// ---------------------------------------------------------------------
	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;

	logic    adv_s2;     // stage 2 may load this cycle
	logic    adv_s1;     // stage 1 transaction moves to stage 2 (state commits)
	logic    accept;

	assign adv_s2     = !valid_s2 || !result_stall;
	assign adv_s1     = valid_s1 && adv_s2;
	assign item_stall = valid_s1 && !adv_s2;
	assign accept     = item_valid && !item_stall;

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// config is to be written only while idle (user's duty, not enforced); always ready
	assign cfg_ready = 1'b1;

	// ---------------------------------------------------------------------
	// Single-pass evaluation of the stage 1 transaction
	// ---------------------------------------------------------------------
	logic [4:0]  ready_src;
	logic        take;
	logic [2:0]  src_idx;
	logic        halted_mid;   // halted bit after a possible dispatch
	logic        wakeable;
	result_t     res_c;

	// lowest pending and enabled source wins
	always_comb begin
		src_idx = '0;
		for (int i = SRC_COUNT - 1; i >= 0; i--) begin
			if (ready_src[i]) begin
				src_idx = 3'(i);
			end
		end
	end

	assign ready_src = flags_q[4:0] & enables_q[4:0];
	assign take      = master_q && (|ready_src);
	assign wakeable  = master_q && (|enables_q[4:0]);
	assign halted_mid = take ? 1'b0 : halted_q;

	always_comb begin
		flags_d    = flags_q;
		enables_d  = enables_q;
		master_d   = master_q;
		halted_d   = halted_q;
		halt_bug_d = halt_bug_q;

		res_c              = '0;

		case (item_s1.action)
			ACT_BOUNDARY: begin
				if (take) begin
					res_c.dispatch     = 1'b1;
					res_c.vector       = VEC_BASE + {1'b0, src_idx, 3'b000};
					res_c.push_address = item_s1.sp_value - PUSH_BYTES;
					res_c.push_value   = item_s1.pc_value;
					res_c.new_sp       = item_s1.sp_value - PUSH_BYTES;
					res_c.wait_cycles  = DISPATCH_COST;
					flags_d            = flags_q & ~(8'd1 << src_idx);
					master_d           = 1'b0;
				end
				halted_d = halted_mid;
				if (halted_mid) begin
					// halted idle: no fetch, wait_cycles set to IDLE_COST
					res_c.wait_cycles = IDLE_COST;
				end else begin
					res_c.fetch   = 1'b1;
					res_c.hold_pc = halt_bug_q;
					halt_bug_d    = 1'b0;
				end
			end
			ACT_WR_FLAGS:   flags_d   = item_s1.data;
			ACT_WR_ENABLES: enables_d = item_s1.data;
			ACT_REQ_VBLANK: flags_d   = flags_q | BIT_VBLANK;
			ACT_REQ_JOYPAD: flags_d   = flags_q | BIT_JOYPAD;
			ACT_REQ_TIMER:  flags_d   = flags_q | BIT_TIMER;
			ACT_HALT: begin
				if (!wakeable) begin
					// nothing could wake the CPU: halt bug or color-model wait
					if (dmg_mode_q) begin
						halt_bug_d = 1'b1;
					end else begin
						res_c.wait_cycles = IDLE_COST;
					end
				end else begin
					halted_d = 1'b1;
				end
			end
			ACT_SET_MASTER: master_d = item_s1.data[0];
			default: ; // read and unused codes change nothing
		endcase

		res_c.flags_read   = flags_d;
		res_c.enables_read = enables_d;
		res_c.is_halted    = halted_d;
	end

	// ---------------------------------------------------------------------
	// Registers
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (adv_s1) begin
			result_s2 <= res_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmg_mode_q <= 1'b1;
			flags_q    <= '0;
			enables_q  <= '0;
			master_q   <= 1'b0;
			halted_q   <= 1'b0;
			halt_bug_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dmg_mode_q <= cfg_data;
			end
			if (adv_s1) begin
				flags_q    <= flags_d;
				enables_q  <= enables_d;
				master_q   <= master_d;
				halted_q   <= halted_d;
				halt_bug_q <= halt_bug_d;
			end
		end
	end

endmodule

/* sv/cidh_checker.sv */
// ----------------------------------------------------------------------------
// cidh_checker
// Port-level checks on the result stream of the interrupt dispatch block.
// ----------------------------------------------------------------------------
module cidh_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              result_valid,
	input logic              result_stall,
	input cidh_pkg::result_t result
);
	import cidh_pkg::*;

	// a dispatch wakes the CPU, fetches and costs the full dispatch time
	a_dispatch_wakes: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.dispatch) |->
			(result.fetch && !result.is_halted && result.wait_cycles == DISPATCH_COST))
		else $error("dispatch result not fetching or wrong cost");

	// dispatch vector is one of the five aligned slots, push address = new sp
	a_vector_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.dispatch) |->
			(result.vector[6] && result.vector[2:0] == 3'b000 &&
			 result.vector[5:3] < 3'(SRC_COUNT) && result.push_address == result.new_sp))
		else $error("bad dispatch vector or stack address");

	// no dispatch means all dispatch fields read zero
	a_no_dispatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.dispatch) |->
			(result.vector == '0 && result.push_address == '0 &&
			 result.push_value == '0 && result.new_sp == '0))
		else $error("dispatch fields set without dispatch");

	// halt-bug hold only comes with a fetch, and a fetching CPU is not halted
	a_hold_needs_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.hold_pc || result.fetch)) |->
			(result.fetch && !result.is_halted))
		else $error("hold_pc without fetch or fetch while halted");

	// stalled result holds
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result changed");

endmodule

bind cpu_interrupt_dispatch_and_halt cidh_checker u_cidh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
